[src/lds_pkg.sv]
// lds_pkg: types, constants and register codes for the low-discrepancy sample generator
// no dependencies; used by lds_lane and ld_02_sample_generator
package lds_pkg;

	localparam int LANES_DEF = 8;

	// configuration registers
	localparam int CFG_DATA_W = 9;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPP_LOG2 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b1;

	localparam logic [4:0] SPP_LOG2_MIN = 5'd3;
	localparam logic [4:0] SPP_LOG2_MAX = 5'd16;
	localparam logic [4:0] SPP_LOG2_RST = 5'd3;
	localparam logic [8:0] BLOCK_MAX = 9'd256;
	localparam logic [8:0] BLOCK_RST = 9'd16;

	// request codes
	localparam logic REQ_SELECT = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// sample count and sample index widths
	localparam int SPP_W = 17;
	localparam int TAKEN_W = 17;
	localparam int K_W = 18;

	typedef struct packed {
		logic        req_type;
		logic [14:0] block_x;
		logic [14:0] block_y;
		logic [31:0] scramble_x;
		logic [31:0] scramble_y;
	} req_t;

	typedef struct packed {
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [23:0] frac_x;
		logic [23:0] frac_y;
		logic        active;
		logic        last;
	} sample_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// generator matrix columns of the second sobol dimension
	function automatic logic [K_W-1:0][31:0] sobol_cols();
		logic [K_W-1:0][31:0] t;
		logic [31:0] col;
		col = 32'h8000_0000;
		for (int j = 0; j < K_W; j++) begin
			t[j] = col;
			col = col ^ (col >> 1);
		end
		return t;
	endfunction

	localparam logic [K_W-1:0][31:0] SOBOL_COL = sobol_cols();

endpackage

[src/ld_02_sample_generator.sv]
// ld_02_sample_generator: top level, request sequencer, pixel walk and result register
// depends on lds_pkg and lds_lane
//
// usage
//  request channel: a beat is taken at a clock edge with start high and busy low
//  a select beat (req_type 0) loads the block origin and rewinds to its first pixel;
//   it gives no results and leaves busy low, so another beat can follow next cycle
//  a sample beat (req_type 1) gives LANES result beats on sample, one per cycle,
//   each marked by sample_valid for exactly one cycle; the first comes out through
//   the state register and then the result register, the last has sample.last set
//  busy stays high through the last lane of a pass, so no new beat is taken during
//   a pass; the one lane unit is stepped once per lane
//  lanes beyond the samples left for the pixel, or with no block open, are inactive
//  configuration: cfg_we writes cfg_data into register cfg_index at once; the user
//   must write only while no pass is running, unenforced; 0 = spp_log2, 1 = block_size
//  reset (arst_n low) clears the sequencer, closes the block and loads the
//   register defaults; no result beat is given during or right after reset
//  the receiver cannot stall: every result beat must be taken when shown
module ld_02_sample_generator import lds_pkg::*; #(
	parameter int LANES = LANES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  request,
	output logic                  sample_valid,
	output sample_t               sample,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

	state_t state_q, state_d;

	logic [4:0]          spp_log2_q;
	logic [8:0]          block_size_q;
	logic                selected_q;
	logic [14:0]         origin_x_q;
	logic [14:0]         origin_y_q;
	logic [15:0]         cur_x_q;
	logic [15:0]         cur_y_q;
	logic [TAKEN_W-1:0]  taken_q;
	logic [31:0]         sx_q;
	logic [31:0]         sy_q;
	logic [LANE_W-1:0]   lane_q;
	logic                sample_valid_q;
	sample_t             sample_q;

	logic [4:0]     spp_l;
	logic [SPP_W-1:0] spp;
	logic [8:0]     bs;
	logic           avail;
	logic [K_W-1:0] k;
	logic           lane_active;
	logic           lane_last;
	logic           advance;
	logic [15:0]    next_x;
	logic           wrap;
	logic [23:0]    frac_x;
	logic [23:0]    frac_y;
	logic           accept;
	sample_t        sample_d;

	// clamp the registers to their usable ranges
	always_comb begin
		if (spp_log2_q < SPP_LOG2_MIN) begin
			spp_l = SPP_LOG2_MIN;
		end else if (spp_log2_q > SPP_LOG2_MAX) begin
			spp_l = SPP_LOG2_MAX;
		end else begin
			spp_l = spp_log2_q;
		end
		spp = SPP_W'(1) << spp_l;
		bs = (block_size_q > BLOCK_MAX) ? BLOCK_MAX : block_size_q;
	end

	assign avail = selected_q && ({1'b0, cur_y_q} < (17'(origin_y_q) + 17'(bs)));
	assign k = K_W'(taken_q) + K_W'(lane_q);
	assign lane_active = avail && (k < K_W'(spp));
	assign lane_last = (lane_q == LANE_W'(LANES - 1));
	// pixel is used up once this pass reaches or passes spp
	assign advance = (K_W'(taken_q) + K_W'(LANES)) >= K_W'(spp);
	assign next_x = cur_x_q + 16'd1;
	assign wrap = {1'b0, next_x} >= (17'(origin_x_q) + 17'(bs));
	assign accept = start && !busy;

	lds_lane u_lane (
		.k          (k),
		.scramble_x (sx_q),
		.scramble_y (sy_q),
		.frac_x     (frac_x),
		.frac_y     (frac_y)
	);

	always_comb begin
		sample_d.last = lane_last;
		sample_d.active = lane_active;
		if (lane_active) begin
			sample_d.pixel_x = cur_x_q;
			sample_d.pixel_y = cur_y_q;
			sample_d.frac_x = frac_x;
			sample_d.frac_y = frac_y;
		end else begin
			sample_d.pixel_x = '0;
			sample_d.pixel_y = '0;
			sample_d.frac_x = '0;
			sample_d.frac_y = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && request.req_type == REQ_SAMPLE) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (lane_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q == ST_RUN);
	end

	assign sample_valid = sample_valid_q;
	assign sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			spp_log2_q <= SPP_LOG2_RST;
			block_size_q <= BLOCK_RST;
			selected_q <= 1'b0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			taken_q <= '0;
			lane_q <= '0;
			sample_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sample_valid_q <= (state_q == ST_RUN);

			if (cfg_we) begin
				unique case (cfg_index)
					REG_SPP_LOG2:   spp_log2_q <= cfg_data[4:0];
					REG_BLOCK_SIZE: block_size_q <= cfg_data[8:0];
					default: ;
				endcase
			end

			if (accept && request.req_type == REQ_SELECT) begin
				origin_x_q <= request.block_x;
				origin_y_q <= request.block_y;
				cur_x_q <= 16'(request.block_x);
				cur_y_q <= 16'(request.block_y);
				taken_q <= '0;
				selected_q <= 1'b1;
			end

			if (accept) begin
				lane_q <= '0;
			end else if (state_q == ST_RUN) begin
				lane_q <= lane_q + LANE_W'(1);
			end

			// pixel walk at the end of a pass
			if (state_q == ST_RUN && lane_last && avail) begin
				if (advance) begin
					taken_q <= '0;
					if (wrap) begin
						cur_x_q <= 16'(origin_x_q);
						cur_y_q <= cur_y_q + 16'd1;
					end else begin
						cur_x_q <= next_x;
					end
				end else begin
					taken_q <= taken_q + TAKEN_W'(LANES);
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= request.scramble_x;
			sy_q <= request.scramble_y;
		end
		if (state_q == ST_RUN) begin
			sample_q <= sample_d;
		end
	end

endmodule

[src/lds_lane.sv]
// lds_lane: shared sample unit, one sample index per cycle to two scrambled fractions
// depends on lds_pkg (sobol columns, index width)
module lds_lane import lds_pkg::*; (
	input  logic [K_W-1:0] k,
	input  logic [31:0]    scramble_x,
	input  logic [31:0]    scramble_y,
	output logic [23:0]    frac_x,
	output logic [23:0]    frac_y
);

	logic [31:0] k32;
	logic [31:0] rev;
	logic [31:0] gen;

	always_comb begin
		k32 = 32'(k);
		for (int i = 0; i < 32; i++) begin
			rev[i] = k32[31-i];
		end
		// gf(2) matrix product: xor of the columns picked by the index bits
		gen = scramble_y;
		for (int j = 0; j < K_W; j++) begin
			if (k[j]) begin
				gen = gen ^ SOBOL_COL[j];
			end
		end
	end

	assign frac_x = rev[31:8] ^ scramble_x[31:8];
	assign frac_y = gen[31:8];

endmodule
